// ===== rtl/core/sbus_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sbus_pkg;

  localparam int FRAME_BYTES = 25;
  localparam int CHANNELS    = 16;
  localparam int ADDR_W      = $clog2(FRAME_BYTES);
  localparam int COUNT_W     = $clog2(FRAME_BYTES + 1);

  localparam logic [7:0] START_MARK = 8'h0F;
  localparam logic [7:0] END_MARK   = 8'h00;
  localparam int FLAG_POS = FRAME_BYTES - 2;
  localparam int LOST_BIT = 2;
  localparam int SAFE_BIT = 3;

  localparam int CH_BITS   = 11;
  localparam int CH_CENTER = 'h3E0;
  // Bit buffer: up to ten leftover bits plus one fresh byte.
  localparam int ACC_W   = CH_BITS + 7;
  localparam int NBITS_W = $clog2(ACC_W + 1);

  localparam logic [15:0] GAP_RESET = 16'd1000;

  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_POLL = 1'b1;

  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [COUNT_W-1:0] count_t;

  typedef struct packed {
    logic       en;
    addr_t      addr;
    logic [7:0] data;
  } mem_wr_t;

  typedef struct packed {
    logic  busy;
    addr_t rd_addr;
  } unpack_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/sbus_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sbus_mem
  import sbus_pkg::*;
(
  input  wire logic       clk,
  input  wire mem_wr_t    wr,
  input  wire addr_t      rd_addr,
  output logic [7:0]      rd_data
);

  logic [7:0] mem [FRAME_BYTES];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ===== rtl/core/sbus_unpack.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sbus_unpack
  import sbus_pkg::*;
#(
  parameter int NUM_CHANNELS = CHANNELS
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [7:0]         rd_data,
  output unpack_stat_t            stat,
  output logic                    chan_valid,
  input  wire logic               chan_ready,
  output logic [3:0]              channel_index,
  output logic signed [10:0]      channel_value,
  output logic                    last_channel
);

  localparam logic [3:0] LAST_CH = 4'(NUM_CHANNELS - 1);

  logic                active;
  logic                pend;
  addr_t               ptr;
  logic [ACC_W-1:0]    acc;
  logic [NBITS_W-1:0]  nbits;
  logic [3:0]          ch;

  logic                emit;
  logic                emit_last;
  logic                fetch;
  logic [ACC_W-1:0]    acc_kept;
  logic [ACC_W-1:0]    acc_next;
  logic [NBITS_W-1:0]  nb_kept;
  logic [NBITS_W-1:0]  nbits_next;

  // (raw - center) * 5 / 8, rounded toward zero.
  function automatic logic signed [10:0] scale(input logic [CH_BITS-1:0] raw);
    logic signed [11:0] d;
    logic signed [13:0] d14;
    logic signed [13:0] p;
    logic signed [13:0] q;
    d   = $signed({1'b0, raw}) - 12'sd992;
    d14 = {{2{d[11]}}, d};
    p   = (d14 <<< 2) + d14;
    q   = p[13] ? ((p + 14'sd7) >>> 3) : (p >>> 3);
    return q[10:0];
  endfunction

  assign emit      = active && (nbits >= NBITS_W'(CH_BITS)) && (!chan_valid || chan_ready);
  assign emit_last = emit && (ch == LAST_CH);

  assign acc_kept   = emit ? (acc >> CH_BITS) : acc;
  assign nb_kept    = emit ? (nbits - NBITS_W'(CH_BITS)) : nbits;
  assign acc_next   = acc_kept | (pend ? (ACC_W'(rd_data) << nb_kept) : '0);
  assign nbits_next = nb_kept + (pend ? NBITS_W'(8) : '0);

  // Keep at most one byte more than the next channel needs in flight.
  assign fetch = active && !emit_last && (ptr <= addr_t'(FRAME_BYTES - 1)) &&
                 (nbits_next < NBITS_W'(CH_BITS));

  assign stat.busy    = active;
  assign stat.rd_addr = ptr;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      pend   <= 1'b0;
    end else if (start) begin
      active <= 1'b1;
      pend   <= 1'b0;
      ptr    <= addr_t'(1);
      acc    <= '0;
      nbits  <= '0;
      ch     <= '0;
    end else if (active) begin
      acc   <= acc_next;
      nbits <= nbits_next;
      pend  <= fetch;
      if (fetch) begin
        ptr <= ptr + addr_t'(1);
      end
      if (emit) begin
        ch <= ch + 4'd1;
      end
      if (emit_last) begin
        active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chan_valid <= 1'b0;
    end else if (emit) begin
      chan_valid <= 1'b1;
    end else if (chan_ready) begin
      chan_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      channel_index <= ch;
      channel_value <= scale(acc[CH_BITS-1:0]);
      last_channel  <= (ch == LAST_CH);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/sbus_frame_receiver.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Frame receiver for a 16-channel serial servo bus.
// Input items (item_valid/item_ready) carry either a received byte or an idle
// poll, each with a 16-bit timer value. A byte item is written into a
// 25-entry frame memory. A poll that finds bytes held and an idle time above
// gap_ticks ends the frame: the count is cleared, and if 25 bytes were held
// the header, flags and end bytes are read back in S_HEAD, S_FLAGS and S_END.
// A bad frame gives no output. A good frame streams its channels out as
// items on chan_valid/chan_ready, lowest channel first, last_channel marking
// the end. The payload bytes are read from the single memory read port only
// as the bit buffer needs them. The input is not ready from the closing poll
// until the last channel has been presented. A stall on the output side halts
// the unpacking; the final channel sits in the output register while new
// input items are already taken. gap_ticks is written through
// gap_we/gap_wdata. Reset clears the byte count, the last byte time and sets
// gap_ticks to 1000; the frame memory is not cleared.

module sbus_frame_receiver
  import sbus_pkg::*;
#(
  parameter int NUM_CHANNELS = CHANNELS
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               gap_we,
  input  wire logic [15:0]        gap_wdata,
  input  wire logic               item_valid,
  output logic                    item_ready,
  input  wire logic               command,
  input  wire logic [7:0]         rx_byte,
  input  wire logic [15:0]        timestamp,
  output logic                    chan_valid,
  input  wire logic               chan_ready,
  output logic [3:0]              channel_index,
  output logic signed [10:0]      channel_value,
  output logic                    last_channel
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_HEAD   = 5'b00010,
    S_FLAGS  = 5'b00100,
    S_END    = 5'b01000,
    S_UNPACK = 5'b10000
  } state_t;

  state_t        state;
  state_t        state_next;
  count_t        byte_count;
  logic [15:0]   last_byte_time;
  logic [15:0]   gap_ticks;
  logic          frame_ok;

  logic          accept;
  logic          close;
  logic          start;
  logic [15:0]   elapsed;
  addr_t         wr_idx;
  addr_t         rd_addr;
  logic [7:0]    rd_data;
  mem_wr_t       wr;
  unpack_stat_t  stat;

  assign item_ready = (state == S_IDLE);
  assign accept     = item_valid && item_ready;
  assign elapsed    = timestamp - last_byte_time;
  assign close      = accept && (command == CMD_POLL) && (byte_count != '0) &&
                      (elapsed > gap_ticks);

  // An overlong frame keeps overwriting the last slot.
  assign wr_idx = (byte_count == count_t'(FRAME_BYTES)) ? addr_t'(FRAME_BYTES - 1)
                                                        : addr_t'(byte_count);

  assign wr.en   = accept && (command == CMD_BYTE);
  assign wr.addr = wr_idx;
  assign wr.data = rx_byte;

  assign start = (state == S_END) && frame_ok && (rd_data == END_MARK);

  // Writes happen only while idle and reads matter only outside idle, so the
  // two ports never touch one entry in a way that needs forwarding.
  always_comb begin
    unique case (state)
      S_IDLE:   rd_addr = '0;
      S_HEAD:   rd_addr = addr_t'(FLAG_POS);
      S_FLAGS:  rd_addr = addr_t'(FRAME_BYTES - 1);
      S_END:    rd_addr = '0;
      S_UNPACK: rd_addr = stat.rd_addr;
      default:  rd_addr = '0;
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (close && (byte_count == count_t'(FRAME_BYTES))) begin
          state_next = S_HEAD;
        end
      end
      S_HEAD:   state_next = S_FLAGS;
      S_FLAGS:  state_next = S_END;
      S_END:    state_next = start ? S_UNPACK : S_IDLE;
      S_UNPACK: begin
        if (!stat.busy) begin
          state_next = S_IDLE;
        end
      end
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      byte_count     <= '0;
      last_byte_time <= '0;
      gap_ticks      <= GAP_RESET;
    end else begin
      state <= state_next;
      if (gap_we) begin
        gap_ticks <= gap_wdata;
      end
      if (wr.en) begin
        byte_count     <= count_t'(wr_idx) + count_t'(1);
        last_byte_time <= timestamp;
      end else if (close) begin
        byte_count <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_HEAD) begin
      frame_ok <= (rd_data == START_MARK);
    end else if (state == S_FLAGS) begin
      frame_ok <= frame_ok && !rd_data[SAFE_BIT] && !rd_data[LOST_BIT];
    end
  end

  sbus_mem u_mem (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  sbus_unpack #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_unpack (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .rd_data       (rd_data),
    .stat          (stat),
    .chan_valid    (chan_valid),
    .chan_ready    (chan_ready),
    .channel_index (channel_index),
    .channel_value (channel_value),
    .last_channel  (last_channel)
  );

endmodule

`default_nettype wire

// ===== rtl/core/sbus_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sbus_checker
  import sbus_pkg::*;
#(
  parameter int NUM_CHANNELS = CHANNELS
) (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              item_ready,
  input wire logic              chan_valid,
  input wire logic              chan_ready,
  input wire logic [3:0]        channel_index,
  input wire logic signed [10:0] channel_value,
  input wire logic              last_channel
);

  // After reset the block takes input and shows no item.
  a_reset: assert property (@(posedge clk) rst |=> (!chan_valid && item_ready))
    else $error("state after reset wrong");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (chan_valid && !chan_ready) |=>
      (chan_valid && $stable(channel_index) && $stable(channel_value)))
    else $error("stalled output item changed");

  // The input stays closed while a frame is still being unpacked.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (chan_valid && !last_channel) |-> !item_ready)
    else $error("input open during unpacking");

  a_last: assert property (@(posedge clk) disable iff (rst)
    (chan_valid && last_channel) |-> (channel_index == 4'(NUM_CHANNELS - 1)))
    else $error("last channel flag on wrong index");

  a_range: assert property (@(posedge clk) disable iff (rst)
    chan_valid |-> ((channel_value >= -11'sd620) && (channel_value <= 11'sd659)))
    else $error("channel value out of range");

endmodule

bind sbus_frame_receiver sbus_checker #(
  .NUM_CHANNELS (NUM_CHANNELS)
) u_checker (
  .clk           (clk),
  .rst           (rst),
  .item_ready    (item_ready),
  .chan_valid    (chan_valid),
  .chan_ready    (chan_ready),
  .channel_index (channel_index),
  .channel_value (channel_value),
  .last_channel  (last_channel)
);

`default_nettype wire

// ===== tb/tb_sbus_frame_receiver.sv =====
`timescale 1ns / 1ps

module tb_sbus_frame_receiver;
  import sbus_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int MAX_PRINTED = 100;
  localparam logic [7:0] FLAG_FAULTS = (8'd1 << LOST_BIT) | (8'd1 << SAFE_BIT);

  typedef struct packed {
    logic [3:0]         index;
    logic signed [10:0] value;
    logic               last;
  } channel_result_t;

  typedef enum int {SLOW_RECEIVER, SLOW_SENDER, NO_STALLS} idle_mode_t;

  typedef enum int {
    FAULT_NONE, BAD_START, BAD_END, LOST_SET, SAFE_SET, SHORT_FRAME, OVERLONG_FRAME
  } frame_fault_t;

  class channel_checker;
    logic [7:0]      frame_buf [FRAME_BYTES];
    int              held_bytes;
    logic [15:0]     byte_stamp;
    logic [15:0]     gap_limit;
    channel_result_t expected_channels [$];
    int              errors;

    function new();
      held_bytes = 0;
      byte_stamp = '0;
      gap_limit  = GAP_RESET;
      errors     = 0;
    endfunction

    function logic frame_is_good();
      if (held_bytes != FRAME_BYTES) return 1'b0;
      if (frame_buf[0] != START_MARK) return 1'b0;
      if (frame_buf[FRAME_BYTES-1] != END_MARK) return 1'b0;
      if ((frame_buf[FLAG_POS] & FLAG_FAULTS) != 8'h00) return 1'b0;
      return 1'b1;
    endfunction

    // Channels are packed little endian, 11 bits each, right after the start byte.
    function logic [10:0] raw_channel(int ch);
      int          bit_pos;
      int          byte_pos;
      logic [23:0] window;
      bit_pos  = ch * CH_BITS;
      byte_pos = 1 + bit_pos / 8;
      window   = '0;
      for (int k = 0; k < 3; k++) begin
        if (byte_pos + k < FRAME_BYTES) window[8*k +: 8] = frame_buf[byte_pos + k];
      end
      return 11'(window >> (bit_pos % 8));
    endfunction

    function void accept_item(logic cmd, logic [7:0] data, logic [15:0] stamp);
      logic [15:0]     idle_ticks;
      logic            good;
      int              scaled;
      channel_result_t res;
      if (cmd == CMD_BYTE) begin
        if (held_bytes > FRAME_BYTES - 1) held_bytes = FRAME_BYTES - 1;
        frame_buf[held_bytes] = data;
        held_bytes++;
        byte_stamp = stamp;
        return;
      end
      if (held_bytes == 0) return;
      idle_ticks = stamp - byte_stamp;
      if (idle_ticks <= gap_limit) return;
      good = frame_is_good();
      held_bytes = 0;
      if (!good) return;
      for (int ch = 0; ch < CHANNELS; ch++) begin
        scaled    = (int'(raw_channel(ch)) - CH_CENTER) * 5 / 8;
        res.index = 4'(ch);
        res.value = scaled[10:0];
        res.last  = (ch == CHANNELS - 1);
        expected_channels.push_back(res);
      end
    endfunction

    task report_mismatch(string what);
      errors++;
      if (errors <= MAX_PRINTED) $display("mismatch: %s", what);
    endtask

    task check_channel(logic [3:0] index, logic signed [10:0] value, logic last);
      channel_result_t want;
      if (expected_channels.size() == 0) begin
        report_mismatch($sformatf("channel item %0d value %0d with none expected",
                                  index, value));
        return;
      end
      want = expected_channels.pop_front();
      if (index !== want.index)
        report_mismatch($sformatf("channel_index %0d, expected %0d", index, want.index));
      if (value !== want.value)
        report_mismatch($sformatf("channel %0d value %0d, expected %0d",
                                  want.index, value, want.value));
      if (last !== want.last)
        report_mismatch($sformatf("channel %0d last_channel %0b, expected %0b",
                                  want.index, last, want.last));
    endtask
  endclass

  logic               clk;
  logic               rst;
  logic               gap_we;
  logic [15:0]        gap_wdata;
  logic               item_valid;
  logic               item_ready;
  logic               command;
  logic [7:0]         rx_byte;
  logic [15:0]        timestamp;
  logic               chan_valid;
  logic               chan_ready;
  logic [3:0]         channel_index;
  logic signed [10:0] channel_value;
  logic               last_channel;

  channel_checker sb = new();

  int          send_idle_pct;
  int          recv_idle_pct;
  int          cur_gap;
  int          items_sent;
  int          cycle_count;
  logic [15:0] byte_time;

  sbus_frame_receiver dut (
    .clk           (clk),
    .rst           (rst),
    .gap_we        (gap_we),
    .gap_wdata     (gap_wdata),
    .item_valid    (item_valid),
    .item_ready    (item_ready),
    .command       (command),
    .rx_byte       (rx_byte),
    .timestamp     (timestamp),
    .chan_valid    (chan_valid),
    .chan_ready    (chan_ready),
    .channel_index (channel_index),
    .channel_value (channel_value),
    .last_channel  (last_channel)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  initial begin
    chan_ready = 1'b0;
    forever begin
      @(negedge clk);
      chan_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && chan_valid && chan_ready)
      sb.check_channel(channel_index, channel_value, last_channel);
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic void set_idling(idle_mode_t mode);
    case (mode)
      SLOW_RECEIVER: begin
        send_idle_pct = 17;
        recv_idle_pct = 55;
      end
      SLOW_SENDER: begin
        send_idle_pct = 55;
        recv_idle_pct = 17;
      end
      default: begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
    endcase
  endfunction

  // Entered and left at a falling edge. Valid is left high after acceptance; the next
  // caller lowers it or replaces the payload at this same falling edge.
  task automatic send_item(input logic cmd, input logic [7:0] data, input logic [15:0] stamp);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid <= 1'b1;
    command    <= cmd;
    rx_byte    <= data;
    timestamp  <= stamp;
    do @(posedge clk); while (!item_ready);
    sb.accept_item(cmd, data, stamp);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    item_valid <= 1'b0;
    while (sb.expected_channels.size() != 0) @(negedge clk);
    @(negedge clk);
  endtask

  task automatic write_gap(input logic [15:0] value);
    drain();
    // A bad frame gives no output, so let the header check finish too.
    repeat (60) @(negedge clk);
    gap_we    <= 1'b1;
    gap_wdata <= value;
    @(negedge clk);
    gap_we       <= 1'b0;
    cur_gap      = value;
    sb.gap_limit = value;
  endtask

  // Closes whatever bytes are still held so the next frame starts clean.
  task automatic flush();
    if (sb.held_bytes != 0 && cur_gap < 65535) begin
      byte_time = sb.byte_stamp + 16'(cur_gap + 1);
      send_item(CMD_POLL, 8'($urandom_range(0, 255)), byte_time);
    end
  endtask

  task automatic send_noise();
    repeat ($urandom_range(1, 4))
      send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                16'($urandom_range(0, 65535)));
    flush();
  endtask

  task automatic send_frame();
    logic [7:0]   frame [$];
    frame_fault_t fault;
    int           pick;
    int           fill;
    int           keep;
    int           gap_over;
    pick  = $urandom_range(0, 15);
    fault = (pick < 10) ? FAULT_NONE : frame_fault_t'(pick - 9);
    fill  = $urandom_range(0, 7);
    for (int i = 0; i < FRAME_BYTES; i++) begin
      if (fill == 0) frame.push_back(8'h00);
      else if (fill == 1) frame.push_back(8'hFF);
      else frame.push_back(8'($urandom_range(0, 255)));
    end
    frame[0]             = START_MARK;
    frame[FLAG_POS]      = frame[FLAG_POS] & ~FLAG_FAULTS;
    frame[FRAME_BYTES-1] = END_MARK;
    case (fault)
      BAD_START: frame[0] = frame[0] ^ (8'd1 << $urandom_range(0, 7));
      BAD_END: frame[FRAME_BYTES-1] = 8'd1 << $urandom_range(0, 7);
      LOST_SET: frame[FLAG_POS] = frame[FLAG_POS] | (8'd1 << LOST_BIT);
      SAFE_SET: begin
        frame[FLAG_POS] = frame[FLAG_POS] | (8'd1 << SAFE_BIT)
                          | (8'($urandom_range(0, 1)) << LOST_BIT);
      end
      SHORT_FRAME: begin
        keep = $urandom_range(1, FRAME_BYTES - 1);
        while (frame.size() > keep) void'(frame.pop_back());
      end
      OVERLONG_FRAME: begin
        repeat ($urandom_range(1, 5)) frame.push_back(8'($urandom_range(0, 255)));
        // Extra bytes land on the end slot, so a trailing end mark keeps it valid.
        if ($urandom_range(0, 1) == 1) frame[frame.size()-1] = END_MARK;
      end
      default: ;
    endcase
    foreach (frame[i]) begin
      byte_time = byte_time + 16'($urandom_range(1, 300));
      send_item(CMD_BYTE, frame[i], byte_time);
      if ($urandom_range(0, 9) == 0)
        send_item(CMD_POLL, 8'($urandom_range(0, 255)),
                  byte_time + 16'($urandom_range(0, cur_gap)));
    end
    if ($urandom_range(0, 3) == 0)
      send_item(CMD_POLL, 8'($urandom_range(0, 255)), byte_time + 16'(cur_gap));
    if (cur_gap < 65535) begin
      if ($urandom_range(0, 1) == 1) gap_over = cur_gap + 1;
      else gap_over = $urandom_range(cur_gap + 1, 65535);
    end else begin
      gap_over = $urandom_range(0, 65535);
    end
    byte_time = byte_time + 16'(gap_over);
    send_item(CMD_POLL, 8'($urandom_range(0, 255)), byte_time);
  endtask

  initial begin
    int         phase_gap [6];
    int         phase_end;
    logic [7:0] data;
    rst        = 1'b1;
    gap_we     = 1'b0;
    gap_wdata  = '0;
    item_valid = 1'b0;
    command    = CMD_BYTE;
    rx_byte    = '0;
    timestamp  = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    cur_gap    = GAP_RESET;
    items_sent = 0;
    byte_time  = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: poll with nothing held, then one frame whose first half of the
    // channels is all zeros and second half all ones, the time wrapping mid-frame.
    set_idling(SLOW_RECEIVER);
    send_item(CMD_POLL, 8'hA5, 16'h1234);
    byte_time = 16'hFF00;
    for (int i = 0; i < FRAME_BYTES; i++) begin
      if (i == 0) data = START_MARK;
      else if (i <= 11) data = 8'h00;
      else if (i < FLAG_POS) data = 8'hFF;
      else if (i == FLAG_POS) data = 8'hF3;
      else data = END_MARK;
      byte_time = byte_time + 16'd120;
      send_item(CMD_BYTE, data, byte_time);
    end
    send_item(CMD_POLL, 8'h00, byte_time + GAP_RESET);
    byte_time = byte_time + GAP_RESET + 16'd1;
    send_item(CMD_POLL, 8'hFF, byte_time);
    drain();

    phase_gap[0] = 0;
    phase_gap[1] = 1;
    phase_gap[2] = 65535;
    phase_gap[3] = $urandom_range(2, 65533);
    phase_gap[4] = 65534;
    phase_gap[5] = GAP_RESET;
    for (int p = 0; p < 6; p++) begin
      set_idling(idle_mode_t'(p / 2));
      write_gap(16'(phase_gap[p]));
      flush();
      // With the widest gap no frame can ever end, so that phase stays short.
      phase_end = items_sent + ((phase_gap[p] == 65535) ? 25 : 60);
      while (items_sent < phase_end) begin
        if ($urandom_range(0, 9) < 8) send_frame();
        else send_noise();
        if ($urandom_range(0, 5) == 0) drain();
      end
    end

    drain();
    repeat (100) @(negedge clk);
    if (sb.expected_channels.size() != 0)
      sb.report_mismatch($sformatf("%0d channel items never arrived",
                                   sb.expected_channels.size()));
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
